@@ hw/rtl/bsf_pkg.sv @@
// ----------------------------------------------------------------------------
// bsf_pkg
// Shared types and constants for the byte-stuffing framer/deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package bsf_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_MODE   = 2'd0;
  localparam logic [1:0] CFG_FLAG   = 2'd1;
  localparam logic [1:0] CFG_ESCAPE = 2'd2;

  localparam logic [7:0] FLAG_RST   = 8'd126;
  localparam logic [7:0] ESCAPE_RST = 8'd125;

  localparam logic MODE_FRAME   = 1'b0;
  localparam logic MODE_DEFRAME = 1'b1;

  // Result kinds
  localparam logic [1:0] KIND_BYTE    = 2'd0;
  localparam logic [1:0] KIND_END     = 2'd1;
  localparam logic [1:0] KIND_NOSTART = 2'd2;
  localparam logic [1:0] KIND_NOEND   = 2'd3;

  // Deframer phases
  localparam logic [1:0] PH_HUNT     = 2'd0;
  localparam logic [1:0] PH_IN       = 2'd1;
  localparam logic [1:0] PH_IN_ESC   = 2'd2;
  localparam logic [1:0] PH_HUNT_ESC = 2'd3;

  // Most results one input byte can cause
  localparam int MAX_RES   = 4;
  localparam int RES_IDX_W = $clog2(MAX_RES);
  localparam int RES_CNT_W = $clog2(MAX_RES + 1);

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_in;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic       last_out;
  } out_word_t;

  typedef struct packed {
    logic [7:0] res_byte;
    logic [1:0] kind;
  } result_t;

  // All results of one input byte, slot 0 first
  typedef struct packed {
    logic [RES_CNT_W-1:0]  count;
    result_t [MAX_RES-1:0] res;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/bsf_front.sv @@
// ----------------------------------------------------------------------------
// bsf_front
// Accepts input words, holds config and framing state, and turns each byte
// into a command listing the results it causes.
// ----------------------------------------------------------------------------
`default_nettype none

module bsf_front import bsf_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire in_word_t    in_word,
  input  wire queue_stat_t q_stat,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data,
  output logic             push,
  output cmd_t             push_cmd
);

  logic       mode_r, mode_nxt;
  logic [7:0] flag_r, flag_nxt;
  logic [7:0] esc_r, esc_nxt;
  logic       started_r, started_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic       accept;

  logic                  st_nxt;
  logic [1:0]            ph_nxt;
  logic [RES_CNT_W-1:0]  cnt;
  result_t [MAX_RES-1:0] res;
  logic [7:0]            b;

  assign accept = in_valid && !q_stat.full;
  assign b      = in_word.data_byte;

  // Result list for the current byte
  always_comb begin
    st_nxt = started_r;
    ph_nxt = phase_r;
    cnt    = '0;
    res    = '0;
    if (mode_r == MODE_FRAME) begin
      if (!started_r) begin
        res[cnt[RES_IDX_W-1:0]] = '{res_byte: flag_r, kind: KIND_BYTE};
        cnt    = cnt + 1'b1;
        st_nxt = 1'b1;
      end
      if (b == flag_r) begin
        res[cnt[RES_IDX_W-1:0]] = '{res_byte: esc_r, kind: KIND_BYTE};
        cnt = cnt + 1'b1;
      end
      res[cnt[RES_IDX_W-1:0]] = '{res_byte: b, kind: KIND_BYTE};
      cnt = cnt + 1'b1;
      if (in_word.last_in) begin
        res[cnt[RES_IDX_W-1:0]] = '{res_byte: flag_r, kind: KIND_BYTE};
        cnt    = cnt + 1'b1;
        st_nxt = 1'b0;
      end
    end else begin
      case (phase_r)
        PH_HUNT: begin
          if (b == flag_r) begin
            ph_nxt = PH_IN;
            st_nxt = 1'b1;
          end else if (b == esc_r) begin
            ph_nxt = PH_HUNT_ESC;
          end
        end
        PH_HUNT_ESC: begin
          // escaped flag is not a start; a further escape keeps the hold
          if (b != flag_r && b == esc_r) ph_nxt = PH_HUNT_ESC;
          else ph_nxt = PH_HUNT;
        end
        PH_IN: begin
          if (b == flag_r) begin
            res[cnt[RES_IDX_W-1:0]] = '{res_byte: 8'd0, kind: KIND_END};
            cnt    = cnt + 1'b1;
            ph_nxt = PH_HUNT;
          end else if (b == esc_r) begin
            ph_nxt = PH_IN_ESC;
          end else begin
            res[cnt[RES_IDX_W-1:0]] = '{res_byte: b, kind: KIND_BYTE};
            cnt = cnt + 1'b1;
          end
        end
        default: begin
          // held escape
          if (b == flag_r) begin
            res[cnt[RES_IDX_W-1:0]] = '{res_byte: b, kind: KIND_BYTE};
            cnt    = cnt + 1'b1;
            ph_nxt = PH_IN;
          end else if (b == esc_r) begin
            res[cnt[RES_IDX_W-1:0]] = '{res_byte: esc_r, kind: KIND_BYTE};
            cnt = cnt + 1'b1;
          end else begin
            res[cnt[RES_IDX_W-1:0]] = '{res_byte: esc_r, kind: KIND_BYTE};
            cnt = cnt + 1'b1;
            res[cnt[RES_IDX_W-1:0]] = '{res_byte: b, kind: KIND_BYTE};
            cnt    = cnt + 1'b1;
            ph_nxt = PH_IN;
          end
        end
      endcase
      if (in_word.last_in) begin
        if (ph_nxt == PH_IN || ph_nxt == PH_IN_ESC) begin
          res[cnt[RES_IDX_W-1:0]] = '{res_byte: 8'd0, kind: KIND_NOEND};
          cnt = cnt + 1'b1;
        end else if (!st_nxt) begin
          res[cnt[RES_IDX_W-1:0]] = '{res_byte: 8'd0, kind: KIND_NOSTART};
          cnt = cnt + 1'b1;
        end
        ph_nxt = PH_HUNT;
        st_nxt = 1'b0;
      end
    end
  end

  assign push           = accept && (cnt != '0);
  assign push_cmd.count = cnt;
  assign push_cmd.res   = res;

  always_comb begin
    mode_nxt    = mode_r;
    flag_nxt    = flag_r;
    esc_nxt     = esc_r;
    started_nxt = started_r;
    phase_nxt   = phase_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_MODE: begin
          mode_nxt    = cfg_data[0];
          started_nxt = 1'b0;
          phase_nxt   = PH_HUNT;
        end
        CFG_FLAG:   flag_nxt = cfg_data;
        CFG_ESCAPE: esc_nxt  = cfg_data;
        default: ;
      endcase
    end else if (accept) begin
      started_nxt = st_nxt;
      phase_nxt   = ph_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_FRAME;
      flag_r    <= FLAG_RST;
      esc_r     <= ESCAPE_RST;
      started_r <= 1'b0;
      phase_r   <= PH_HUNT;
    end else begin
      mode_r    <= mode_nxt;
      flag_r    <= flag_nxt;
      esc_r     <= esc_nxt;
      started_r <= started_nxt;
      phase_r   <= phase_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/bsf_queue.sv @@
// ----------------------------------------------------------------------------
// bsf_queue
// Small command FIFO between front and back; push and pop in one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bsf_queue import bsf_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  wire cmd_t   push_cmd,
  input  wire logic   pop,
  output cmd_t        head_cmd,
  output queue_stat_t q_stat
);

  cmd_t                slot_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CW-1:0] cnt_r, cnt_nxt;

  assign head_cmd     = slot_r[rd_ptr_r];
  assign q_stat.full  = (cnt_r == QUEUE_CW'(QUEUE_DEPTH));
  assign q_stat.empty = (cnt_r == '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop)      cnt_nxt = cnt_r + 1'b1;
    else if (!push && pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/bsf_back.sv @@
// ----------------------------------------------------------------------------
// bsf_back
// Walks the head command one result per unstalled cycle into the output reg.
// ----------------------------------------------------------------------------
`default_nettype none

module bsf_back import bsf_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cmd_t        head_cmd,
  input  wire queue_stat_t q_stat,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_word_t        out_word
);

  logic [RES_IDX_W-1:0] idx_r, idx_nxt;
  logic                 valid_r, valid_nxt;
  out_word_t            word_r;
  logic                 load, take, is_last;
  result_t              sel;

  assign load    = !valid_r || !out_stall;
  assign take    = load && !q_stat.empty;
  assign sel     = head_cmd.res[idx_r];
  assign is_last = ({1'b0, idx_r} + 1'b1) == head_cmd.count;
  assign pop     = take && is_last;

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    if (load) valid_nxt = !q_stat.empty;
    if (take) idx_nxt = is_last ? '0 : idx_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (take) begin
      word_r.out_byte <= sel.res_byte;
      word_r.kind     <= sel.kind;
      word_r.last_out <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_word  = word_r;

endmodule

`default_nettype wire

@@ hw/rtl/byte_stuffing_framer.sv @@
// ----------------------------------------------------------------------------
// byte_stuffing_framer
// Flag/escape byte-stuffing framer (mode 0) and deframer (mode 1).
// ----------------------------------------------------------------------------
// One byte word enters per cycle while in_stall is low. Each byte causes zero
// to four result words (opening flag, escape, byte, closing flag when framing;
// data, end of frame, missing start or missing end when deframing), which
// leave one per cycle, when not stalled, from a registered output, last_out
// marking the final result of a byte. The input side keeps taking bytes until
// the two-entry command queue between the classifying front and the output
// back is full, so one result per byte sustains one byte per cycle when the
// output is not stalled. A taken byte's command passes the queue, then the
// output register. Config registers (mode, flag_byte, escape_byte) are written
// through cfg_we/cfg_index/cfg_data; the user must write them only while the
// block is idle (not enforced); any write to mode restarts framing state.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_stuffing_framer import bsf_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // input channel
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire in_word_t   in_word,
  // result channel
  output logic            out_valid,
  input  wire logic       out_stall,
  output out_word_t       out_word,
  // config writes
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  queue_stat_t q_stat;
  logic        push, pop;
  cmd_t        push_cmd, head_cmd;

  // back-pressure on input only when no queue slot is free
  assign in_stall = q_stat.full;

  // front: config, state, byte -> command
  bsf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_word   (in_word),
    .q_stat    (q_stat),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  // decoupling queue
  bsf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .q_stat   (q_stat)
  );

  // back: command -> result words
  bsf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_cmd  (head_cmd),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

`default_nettype wire
